/* rtl/rsa_modexp_cipher_top_defines.svh */
// ----------------------------------------------------------------------------
// rsa_modexp_cipher_top_defines
// assertion macros for the modular exponentiation block
// ----------------------------------------------------------------------------
`ifndef RSA_MODEXP_CIPHER_TOP_DEFINES_SVH
`define RSA_MODEXP_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define RMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmc assertion failed");

// next-cycle implication, checked outside reset
`define RMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmc assertion failed");

`else

`define RMC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/rmc_pkg.sv */
// ----------------------------------------------------------------------------
// rmc_pkg
// shared widths, register indexes, sequencer states and unit interface types
// ----------------------------------------------------------------------------
package rmc_pkg;

    // data word and exponent widths
    localparam int WIDTH     = 16;
    localparam int EXP_BITS  = 16;
    localparam int CNT_W     = (WIDTH > 2) ? $clog2(WIDTH) : 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = (WIDTH > EXP_BITS) ? WIDTH : EXP_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENC_EXP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_EXP = 2'd2;

    // exponentiation sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_GO,
        S_RED_WAIT,
        S_CHECK,
        S_MUL_GO,
        S_MUL_WAIT,
        S_SQR_GO,
        S_SQR_WAIT,
        S_DONE
    } t_state;

    // request to the modular multiplier
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] op_a;   // must be below the modulus
        logic [WIDTH-1:0] op_b;   // any value
    } t_mm_req;

    // response from the modular multiplier
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] product;
    } t_mm_rsp;

endpackage

/* rtl/rmc_modmul.sv */
// ----------------------------------------------------------------------------
// rmc_modmul
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module rmc_modmul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rmc_pkg::t_mm_req           i_req,
    input  logic [rmc_pkg::WIDTH-1:0]  i_modulus,
    output rmc_pkg::t_mm_rsp           o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [rmc_pkg::CNT_W-1:0]   r_cnt;
    logic [rmc_pkg::WIDTH-1:0]   r_acc;
    logic [rmc_pkg::WIDTH-1:0]   r_a;
    logic [rmc_pkg::WIDTH-1:0]   r_b;

    logic [rmc_pkg::WIDTH+1:0]   w_sum;
    logic [rmc_pkg::WIDTH+2:0]   w_d1;
    logic [rmc_pkg::WIDTH+2:0]   w_d2;
    logic [rmc_pkg::WIDTH-1:0]   n_acc;

    // acc = 2*acc + bit*a, below 3n, then pull back under n
    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0}
              + (r_b[rmc_pkg::WIDTH-1] ? {2'b00, r_a} : '0);
        w_d1  = {1'b0, w_sum} - {3'b000, i_modulus};
        w_d2  = {1'b0, w_sum} - {2'b00, i_modulus, 1'b0};
        priority if (!w_d2[rmc_pkg::WIDTH+2]) begin
            n_acc = w_d2[rmc_pkg::WIDTH-1:0];
        end else if (!w_d1[rmc_pkg::WIDTH+2]) begin
            n_acc = w_d1[rmc_pkg::WIDTH-1:0];
        end else begin
            n_acc = w_sum[rmc_pkg::WIDTH-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= rmc_pkg::CNT_W'(rmc_pkg::WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.op_a;
            r_b   <= i_req.op_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[rmc_pkg::WIDTH-2:0], 1'b0};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

/* rtl/rsa_modexp_cipher_top.sv */
// ----------------------------------------------------------------------------
// rsa_modexp_cipher_top
// word-wide modular exponentiation, encrypt or decrypt per beat
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a data word on tdata, the operation on tuser (0 public
//   exponent, 1 private exponent) and a last-of-message flag on tlast. Each
//   input beat yields one output beat: the word raised to the chosen exponent
//   modulo the modulus register, with tlast copied through.
//   One word is worked at a time; o_s_tready is high only while the
//   sequencer is idle. The power is built right to left by square-and-multiply
//   on one shared bit-serial modular multiplier. A word costs one reduction,
//   a check step per exponent bit up to the highest set one, a multiply per
//   set bit and a square per bit below it. A zero word or a modulus below two
//   skips the multiplier and yields zero. The result sits in an output
//   register; a stalled receiver holds it there while the next word is
//   already accepted and worked. Configuration writes go through the write
//   port; the user must issue them only while no word is in flight, as the
//   block itself does not enforce this.
//   Reset (synchronous, active low) empties the output and restores modulus
//   91 and both exponents 19.
// ----------------------------------------------------------------------------
`include "rsa_modexp_cipher_top_defines.svh"

module rsa_modexp_cipher_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rmc_pkg::WIDTH-1:0]       i_s_tdata,   // [15:0] data_value
    input  logic [0:0]                      i_s_tuser,   // [0] operation
    input  logic                            i_s_tlast,
    // output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rmc_pkg::WIDTH-1:0]       o_m_tdata,   // [15:0] result_value
    output logic                            o_m_tlast,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [rmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rmc_pkg::CFG_W-1:0]       i_cfg_wdata
);

    rmc_pkg::t_state                 r_state;
    rmc_pkg::t_state                 n_state;

    logic [rmc_pkg::WIDTH-1:0]       r_modulus;
    logic [rmc_pkg::EXP_BITS-1:0]    r_enc_exp;
    logic [rmc_pkg::EXP_BITS-1:0]    r_dec_exp;

    logic [rmc_pkg::WIDTH-1:0]       r_base;
    logic [rmc_pkg::EXP_BITS-1:0]    r_exp;
    logic [rmc_pkg::WIDTH-1:0]       r_acc;
    logic [rmc_pkg::WIDTH-1:0]       r_sq;
    logic                            r_last;

    logic                            r_out_valid;
    logic [rmc_pkg::WIDTH-1:0]       r_out_data;
    logic                            r_out_last;

    logic                            w_in_acc;
    logic                            w_trivial;
    logic                            w_out_free;
    logic                            w_zero_in;
    logic                            w_mm_wait;
    logic                            w_check_ok;
    rmc_pkg::t_mm_req                w_mm_req;
    rmc_pkg::t_mm_rsp                w_mm_rsp;

    assign o_s_tready = (r_state == rmc_pkg::S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_trivial  = (i_s_tdata == '0) || (r_modulus < rmc_pkg::WIDTH'(2));
    assign w_out_free = !r_out_valid || i_m_tready;

    // shared modular multiplier
    rmc_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mm_req),
        .i_modulus (r_modulus),
        .o_rsp     (w_mm_rsp)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= rmc_pkg::WIDTH'(91);
            r_enc_exp <= rmc_pkg::EXP_BITS'(19);
            r_dec_exp <= rmc_pkg::EXP_BITS'(19);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rmc_pkg::REG_MODULUS: r_modulus <= i_cfg_wdata[rmc_pkg::WIDTH-1:0];
                rmc_pkg::REG_ENC_EXP: r_enc_exp <= i_cfg_wdata[rmc_pkg::EXP_BITS-1:0];
                rmc_pkg::REG_DEC_EXP: r_dec_exp <= i_cfg_wdata[rmc_pkg::EXP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmc_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_trivial ? rmc_pkg::S_DONE : rmc_pkg::S_RED_GO;
                end
            end
            rmc_pkg::S_RED_GO:   n_state = rmc_pkg::S_RED_WAIT;
            rmc_pkg::S_RED_WAIT: begin
                if (w_mm_rsp.done) begin
                    n_state = rmc_pkg::S_CHECK;
                end
            end
            rmc_pkg::S_CHECK: begin
                priority if (r_exp == '0) begin
                    n_state = rmc_pkg::S_DONE;
                end else if (r_exp[0]) begin
                    n_state = rmc_pkg::S_MUL_GO;
                end else begin
                    n_state = rmc_pkg::S_SQR_GO;
                end
            end
            rmc_pkg::S_MUL_GO:   n_state = rmc_pkg::S_MUL_WAIT;
            rmc_pkg::S_MUL_WAIT: begin
                if (w_mm_rsp.done) begin
                    // no higher exponent bits: the square is not needed
                    n_state = (r_exp[rmc_pkg::EXP_BITS-1:1] == '0) ? rmc_pkg::S_DONE
                                                                   : rmc_pkg::S_SQR_GO;
                end
            end
            rmc_pkg::S_SQR_GO:   n_state = rmc_pkg::S_SQR_WAIT;
            rmc_pkg::S_SQR_WAIT: begin
                if (w_mm_rsp.done) begin
                    n_state = rmc_pkg::S_CHECK;
                end
            end
            rmc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = rmc_pkg::S_IDLE;
                end
            end
            default: n_state = rmc_pkg::S_IDLE;
        endcase
    end

    // multiplier requests
    always_comb begin
        w_mm_req = '0;
        unique case (r_state)
            rmc_pkg::S_RED_GO: begin
                // base mod n as 1 * base
                w_mm_req.start = 1'b1;
                w_mm_req.op_a  = rmc_pkg::WIDTH'(1);
                w_mm_req.op_b  = r_base;
            end
            rmc_pkg::S_MUL_GO: begin
                w_mm_req.start = 1'b1;
                w_mm_req.op_a  = r_sq;
                w_mm_req.op_b  = r_acc;
            end
            rmc_pkg::S_SQR_GO: begin
                w_mm_req.start = 1'b1;
                w_mm_req.op_a  = r_sq;
                w_mm_req.op_b  = r_sq;
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_base <= i_s_tdata;
            r_exp  <= i_s_tuser[0] ? r_dec_exp : r_enc_exp;
            r_acc  <= w_trivial ? '0 : rmc_pkg::WIDTH'(1);
            r_last <= i_s_tlast;
        end
        if (w_mm_rsp.done) begin
            unique case (r_state)
                rmc_pkg::S_RED_WAIT: r_sq <= w_mm_rsp.product;
                rmc_pkg::S_MUL_WAIT: r_acc <= w_mm_rsp.product;
                rmc_pkg::S_SQR_WAIT: begin
                    r_sq  <= w_mm_rsp.product;
                    r_exp <= r_exp >> 1;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == rmc_pkg::S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == rmc_pkg::S_DONE) && w_out_free) begin
            r_out_data <= r_acc;
            r_out_last <= r_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // check terms
    assign w_zero_in  = w_in_acc && (i_s_tdata == '0);
    assign w_mm_wait  = (r_state == rmc_pkg::S_RED_WAIT)
                     || (r_state == rmc_pkg::S_MUL_WAIT)
                     || (r_state == rmc_pkg::S_SQR_WAIT);
    assign w_check_ok = (r_acc < r_modulus) && (r_sq < r_modulus);

    // checks
    `RMC_ASSERT_NEXT(a_zero_word_short, i_clk, i_rst_n, w_zero_in, r_state == rmc_pkg::S_DONE)
    `RMC_ASSERT_NOW(a_mm_done_in_wait, i_clk, i_rst_n, w_mm_rsp.done, w_mm_wait)
    `RMC_ASSERT_NOW(a_acc_reduced, i_clk, i_rst_n, r_state == rmc_pkg::S_CHECK, w_check_ok)

endmodule

/* verif/rsa_modexp_cipher_top_test.sv */
// ----------------------------------------------------------------------------
// rsa_modexp_cipher_top_test
// self-checking bench for the modular exponentiation cipher
// ----------------------------------------------------------------------------
// A queue of words is streamed into the block by a clocked driver. Each
// accepted beat is run through a square-and-multiply model in the bench,
// using the bench's own copy of modulus and exponents, and the predicted
// word and last flag are queued. A clocked monitor compares every output
// beat against the oldest prediction. The run moves through several key
// settings, including the register extremes and a modulus below two. It
// uses several flow-control mixes and one long output stall that backs up
// the input side.
// ----------------------------------------------------------------------------
module rsa_modexp_cipher_top_test;

    localparam logic         OP_ENCRYPT       = 1'b0;
    localparam logic         OP_DECRYPT       = 1'b1;
    localparam int           LONG_HOLD_CYCLES = 3000;
    localparam int           CYCLE_LIMIT      = 4_000_000;
    localparam int           RANDOM_PHASES    = 12;
    localparam int           WORDS_PER_PHASE  = 80;
    localparam int           SETTLE_CYCLES    = 700;

    // one input beat
    typedef struct packed {
        logic [rmc_pkg::WIDTH-1:0] word;
        logic                      op;
        logic                      last;
    } t_cipher_word;

    // one output beat
    typedef struct packed {
        logic [rmc_pkg::WIDTH-1:0] value;
        logic                      last;
    } t_cipher_result;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_s_tvalid  = 1'b0;
    logic                              o_s_tready;
    logic [rmc_pkg::WIDTH-1:0]         i_s_tdata   = '0;   // [15:0] data_value
    logic [0:0]                        i_s_tuser   = '0;   // [0] operation
    logic                              i_s_tlast   = 1'b0;
    logic                              o_m_tvalid;
    logic                              i_m_tready  = 1'b0;
    logic [rmc_pkg::WIDTH-1:0]         o_m_tdata;          // [15:0] result_value
    logic                              o_m_tlast;
    logic                              i_cfg_wr_en = 1'b0;
    logic [rmc_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [rmc_pkg::CFG_W-1:0]         i_cfg_wdata = '0;

    // bench copy of the key registers, reset values
    logic [rmc_pkg::WIDTH-1:0]         modulus_r = 16'd91;
    logic [rmc_pkg::EXP_BITS-1:0]      enc_exp_r = 16'd19;
    logic [rmc_pkg::EXP_BITS-1:0]      dec_exp_r = 16'd19;

    t_cipher_word          word_pending[$];
    t_cipher_result        cipher_expected[$];
    int unsigned           send_idle_pct  = 0;
    int unsigned           recv_stall_pct = 0;
    int unsigned           hold_requests  = 0;
    int unsigned           hold_seen      = 0;
    int unsigned           hold_left      = 0;
    int unsigned           fail_count     = 0;
    int unsigned           cycle_count    = 0;

    rsa_modexp_cipher_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // word ^ exponent mod modulus, right to left, double-width products
    function automatic logic [rmc_pkg::WIDTH-1:0] expected_power(
        input logic [rmc_pkg::WIDTH-1:0] word,
        input logic                      op
    );
        logic [rmc_pkg::EXP_BITS-1:0] expo;
        logic [2*rmc_pkg::WIDTH-1:0]  n;
        logic [2*rmc_pkg::WIDTH-1:0]  acc;
        logic [2*rmc_pkg::WIDTH-1:0]  sq;
        expo = (op == OP_DECRYPT) ? dec_exp_r : enc_exp_r;
        n    = {{rmc_pkg::WIDTH{1'b0}}, modulus_r};
        // zero word and degenerate modulus both give zero
        if (word == '0 || modulus_r < 2)
            return '0;
        acc = 1;
        sq  = {{rmc_pkg::WIDTH{1'b0}}, word} % n;
        for (int b = 0; b < rmc_pkg::EXP_BITS; b++) begin
            if (expo[b])
                acc = (acc * sq) % n;
            sq = (sq * sq) % n;
        end
        return acc[rmc_pkg::WIDTH-1:0];
    endfunction

    // driver: predicts at acceptance, then offers the next queued word
    always @(posedge i_clk) begin : driver
        t_cipher_word   nxt;
        t_cipher_result pred;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pred.value = expected_power(i_s_tdata, i_s_tuser[0]);
                pred.last  = i_s_tlast;
                cipher_expected = {cipher_expected, pred};
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (word_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = word_pending.pop_front();
                    i_s_tdata  <= nxt.word;
                    i_s_tuser  <= nxt.op;
                    i_s_tlast  <= nxt.last;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks output beats, drives ready with stalls and hold-offs
    always @(posedge i_clk) begin : monitor
        t_cipher_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (cipher_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 20)
                        $display("%0t: unexpected result beat: expected none, got %h last %b",
                                 $time, o_m_tdata, o_m_tlast);
                end else begin
                    want = cipher_expected.pop_front();
                    if (o_m_tdata !== want.value || o_m_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= 20)
                            $display("%0t: result mismatch: expected %h last %b, got %h last %b",
                                     $time, want.value, want.last, o_m_tdata, o_m_tlast);
                    end
                end
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_word(input logic [rmc_pkg::WIDTH-1:0] word,
                              input logic                      op,
                              input logic                      last);
        t_cipher_word w;
        w.word = word;
        w.op   = op;
        w.last = last;
        word_pending = {word_pending, w};
    endtask

    // one register write per clock, shadow copy follows
    task automatic write_reg(input logic [rmc_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned                   value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value[rmc_pkg::CFG_W-1:0];
        case (idx)
            rmc_pkg::REG_MODULUS: modulus_r = value[rmc_pkg::WIDTH-1:0];
            rmc_pkg::REG_ENC_EXP: enc_exp_r = value[rmc_pkg::EXP_BITS-1:0];
            rmc_pkg::REG_DEC_EXP: dec_exp_r = value[rmc_pkg::EXP_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_key(input int unsigned n, input int unsigned e, input int unsigned d);
        write_reg(rmc_pkg::REG_MODULUS, n);
        write_reg(rmc_pkg::REG_ENC_EXP, e);
        write_reg(rmc_pkg::REG_DEC_EXP, d);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // wait until every queued word is in and every result is out
    task automatic drain_all();
        do
            @(negedge i_clk);
        while (word_pending.size() != 0 || i_s_tvalid || cipher_expected.size() != 0);
    endtask

    function automatic int unsigned random_exponent();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        else if (r == 1)
            return 65535;
        else if (r < 4)
            return $urandom_range(0, 65535);
        return $urandom_range(1, 255);
    endfunction

    // stimulus sequence
    initial begin
        int unsigned n;
        int unsigned r;
        logic [rmc_pkg::WIDTH-1:0] word;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key: zero word, small words, words at and above modulus
        queue_word(16'd0,     OP_ENCRYPT, 1'b0);
        queue_word(16'd0,     OP_DECRYPT, 1'b1);
        queue_word(16'd1,     OP_ENCRYPT, 1'b0);
        queue_word(16'd1,     OP_DECRYPT, 1'b0);
        queue_word(16'd90,    OP_ENCRYPT, 1'b0);
        queue_word(16'd91,    OP_ENCRYPT, 1'b0);
        queue_word(16'd92,    OP_DECRYPT, 1'b0);
        queue_word(16'hFFFF,  OP_ENCRYPT, 1'b1);
        queue_word(16'hAAAA,  OP_DECRYPT, 1'b0);
        queue_word(16'h5555,  OP_ENCRYPT, 1'b0);
        queue_word(16'd2,     OP_DECRYPT, 1'b1);
        drain_all();

        // largest modulus and exponent, zero private exponent
        load_key(65535, 65535, 0);
        queue_word(16'hFFFF,  OP_ENCRYPT, 1'b0);
        queue_word(16'hFFFE,  OP_ENCRYPT, 1'b0);
        queue_word(16'hFFFE,  OP_DECRYPT, 1'b0);
        queue_word(16'd12345, OP_DECRYPT, 1'b0);
        queue_word(16'd0,     OP_DECRYPT, 1'b0);
        queue_word(16'd2,     OP_ENCRYPT, 1'b1);
        drain_all();

        // smallest legal modulus
        load_key(2, 1, 65534);
        queue_word(16'd1,     OP_ENCRYPT, 1'b0);
        queue_word(16'd3,     OP_DECRYPT, 1'b0);
        queue_word(16'hFFFF,  OP_DECRYPT, 1'b0);
        queue_word(16'h8000,  OP_ENCRYPT, 1'b1);
        drain_all();

        // modulus zero and one give zero
        load_key(0, 5, 7);
        queue_word(16'd7,     OP_ENCRYPT, 1'b0);
        queue_word(16'd9,     OP_DECRYPT, 1'b1);
        drain_all();
        load_key(1, 3, 3);
        queue_word(16'd7,     OP_ENCRYPT, 1'b0);
        queue_word(16'd0,     OP_DECRYPT, 1'b1);
        drain_all();

        // random keys and words under rotating flow-control mixes
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                n = 65535;
            else if (r == 1)
                n = $urandom_range(2, 300);
            else
                n = $urandom_range(2, 65535);
            load_key(n, random_exponent(), random_exponent());
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int j = 0; j < WORDS_PER_PHASE; j++) begin
                r = $urandom_range(0, 15);
                if (r == 0)
                    word = '0;
                else if (r == 1)
                    word = '1;
                else if (r == 2)
                    word = rmc_pkg::WIDTH'($urandom_range(1, (n > 2) ? n - 1 : 1));
                else
                    word = rmc_pkg::WIDTH'($urandom_range(0, 65535));
                queue_word(word, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
            end
            // long output stall while the sender keeps offering
            if (k == 4)
                hold_requests++;
            drain_all();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
